>>> hw/rtl/rhrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhrb_pkg
// Types, codes and helpers shared by the signal strength history buffer.
// ----------------------------------------------------------------------------
package rhrb_pkg;

  localparam int HISTORY_DEPTH_DEFAULT = 64;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_HISTORY = 2'd1;
  localparam logic [1:0] MODE_LATEST  = 2'd2;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_EMPTY  = 2'd1;
  localparam logic [1:0] KIND_LATEST = 2'd2;

  localparam logic signed [31:0] WIDE_ABSENT   = 32'sh8000_0000;
  localparam logic signed [7:0]  NARROW_ABSENT = 8'sh80;
  localparam logic signed [15:0] SAMPLE_NONE   = 16'sh8000;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] wide_reading;
    logic signed [7:0]  narrow_reading;
    logic [7:0]         capacity;
  } rhrb_in_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [15:0] sample_value;
    logic [5:0]         position;
    logic [6:0]         returned_count;
    logic               last;
    logic signed [31:0] latest_wide;
    logic signed [7:0]  latest_narrow;
  } rhrb_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tick;
    logic start_read;
    logic load_direct;
    logic issue;
  } rhrb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hist_empty;
    logic issue_ok;
    logic issue_last;
    logic out_load;
  } rhrb_stat_t;

  // The wide reading wins when present, then the narrow one, else the floor.
  function automatic logic signed [15:0] pick_sample(logic signed [31:0] wide,
                                                    logic signed [7:0] narrow);
    logic signed [15:0] res;
    if (wide != WIDE_ABSENT) begin
      res = wide[15:0];
    end else if (narrow != NARROW_ABSENT) begin
      res = {{8{narrow[7]}}, narrow};
    end else begin
      res = SAMPLE_NONE;
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/rhrb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhrb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rhrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    // Read data holds while no read is issued.
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/rhrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhrb_ctrl
// Controller: takes requests, sequences history reads and waits for drain.
// ----------------------------------------------------------------------------
module rhrb_ctrl import rhrb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_mode,
  output logic       in_stall,
  input  rhrb_stat_t stat,
  output rhrb_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_STREAM = 3'b010,
    ST_DRAIN  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);

  always_comb begin
    cmd.tick        = accept && (in_mode == MODE_TICK);
    cmd.start_read  = accept && (in_mode == MODE_HISTORY) && !stat.hist_empty;
    cmd.load_direct = accept && (((in_mode == MODE_HISTORY) && stat.hist_empty) ||
                                 (in_mode == MODE_LATEST));
    cmd.issue       = (state == ST_STREAM) && stat.issue_ok;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.start_read) begin
          state_next = ST_STREAM;
        end else if (cmd.load_direct) begin
          state_next = ST_DRAIN;
        end
      end
      ST_STREAM: begin
        if (cmd.issue && stat.issue_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The final result has left the staging register.
        if (stat.out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/rhrb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhrb_datapath
// Ring store, fill and index registers, read run counters and result stages.
// ----------------------------------------------------------------------------
module rhrb_datapath import rhrb_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  rhrb_in_t   in_item,
  input  rhrb_cmd_t  cmd,
  output rhrb_stat_t stat,
  output logic       out_valid,
  input  logic       out_stall,
  output rhrb_out_t  out_item
);

  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HISTORY_DEPTH);

  logic [IDX_W-1:0]   write_index;
  logic [CNT_W-1:0]   fill_count;
  logic signed [31:0] latest_wide_reg;
  logic signed [7:0]  latest_narrow_reg;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] rd_pos;
  logic [CNT_W-1:0] run_count;

  logic             s1_valid;
  rhrb_out_t        s1_item;
  rhrb_out_t        s1_item_next;
  rhrb_out_t        out_item_next;
  logic [15:0]      ram_rdata;

  logic [CNT_W-1:0] run_n;
  logic [IDX_W-1:0] oldest;
  logic [IDX_W:0]   start_sum;
  logic [IDX_W-1:0] start_idx;
  logic             out_load;

  // Samples returned: the smaller of the fill count and the reader's capacity.
  always_comb begin
    if (8'(fill_count) > in_item.capacity) begin
      run_n = in_item.capacity[CNT_W-1:0];
    end else begin
      run_n = fill_count;
    end
    oldest    = (fill_count == FULL_CNT) ? write_index : '0;
    start_sum = (IDX_W + 1)'(oldest) + (IDX_W + 1)'(fill_count - run_n);
    if (start_sum >= (IDX_W + 1)'(HISTORY_DEPTH)) begin
      start_idx = IDX_W'(start_sum - (IDX_W + 1)'(HISTORY_DEPTH));
    end else begin
      start_idx = start_sum[IDX_W-1:0];
    end
  end

  assign out_load = s1_valid && (!out_valid || !out_stall);

  always_comb begin
    stat.hist_empty = (run_n == '0);
    stat.issue_ok   = !s1_valid || out_load;
    stat.issue_last = ((CNT_W'(rd_pos) + CNT_W'(1)) == run_count);
    stat.out_load   = out_load;
  end

  rhrb_ram #(
    .WIDTH (16),
    .DEPTH (HISTORY_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (cmd.tick),
    .wr_addr (write_index),
    .wr_data (pick_sample(in_item.wide_reading, in_item.narrow_reading)),
    .re      (cmd.issue),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // Architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index       <= '0;
      fill_count        <= '0;
      latest_wide_reg   <= WIDE_ABSENT;
      latest_narrow_reg <= NARROW_ABSENT;
    end else if (cmd.tick) begin
      write_index       <= (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
      if (fill_count != FULL_CNT) begin
        fill_count <= fill_count + 1'b1;
      end
      latest_wide_reg   <= in_item.wide_reading;
      latest_narrow_reg <= in_item.narrow_reading;
    end
  end

  // Read run counters.
  always_ff @(posedge clk) begin
    if (cmd.start_read) begin
      rd_addr   <= start_idx;
      rd_pos    <= '0;
      run_count <= run_n;
    end else if (cmd.issue) begin
      rd_addr <= (rd_addr == LAST_IDX) ? '0 : rd_addr + 1'b1;
      rd_pos  <= rd_pos + 1'b1;
    end
  end

  always_comb begin
    s1_item_next = s1_item;
    if (cmd.issue) begin
      s1_item_next                = '0;
      s1_item_next.result_kind    = KIND_SAMPLE;
      s1_item_next.position       = 6'(rd_pos);
      s1_item_next.returned_count = 7'(run_count);
      s1_item_next.last           = stat.issue_last;
    end else if (cmd.load_direct) begin
      s1_item_next      = '0;
      s1_item_next.last = 1'b1;
      if (in_item.mode == MODE_LATEST) begin
        s1_item_next.result_kind   = KIND_LATEST;
        s1_item_next.latest_wide   = latest_wide_reg;
        s1_item_next.latest_narrow = latest_narrow_reg;
      end else begin
        s1_item_next.result_kind = KIND_EMPTY;
      end
    end
  end

  // Staging register, aligned with the RAM read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue || cmd.load_direct || (s1_valid && !out_load);
    end
    s1_item <= s1_item_next;
  end

  always_comb begin
    out_item_next = s1_item;
    if (s1_item.result_kind == KIND_SAMPLE) begin
      out_item_next.sample_value = ram_rdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
    end
    if (out_load) begin
      out_item <= out_item_next;
    end
  end

endmodule

>>> hw/rtl/rssi_history_ring_buffer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_history_ring_buffer_unit
// Ring of link signal strength samples with history and latest reads.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid / in_stall / in_item and results leave on
// out_valid / out_stall / out_item; a transfer happens when valid is high and
// stall is low. A sample tick writes the ring in the cycle it is accepted and
// returns nothing. A history read returns min(capacity, fill) samples, oldest
// first, or one empty result; a latest read returns one result.
// The first sample of a history read goes through the read address register,
// the RAM read into the staging register and the output register; further
// samples follow one per cycle while the receiver does not stall. An empty or
// latest result passes from the staging register into the output register.
// The unit takes one request at a time; a read keeps it busy until its final
// result has entered the output register, while a tick leaves it idle.
// When the receiver stalls, the output register and the staging register
// hold and RAM reads pause; no result is lost. in_stall is high from the
// acceptance of a read until its final result has entered the output register.
// Reset clears the write index and fill count and sets the latest readings to
// their absent values; ring contents are not cleared.
// ----------------------------------------------------------------------------
module rssi_history_ring_buffer_unit import rhrb_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  rhrb_in_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output rhrb_out_t out_item
);

  rhrb_cmd_t  cmd;
  rhrb_stat_t stat;

  rhrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (in_item.mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rhrb_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // A RAM read is only issued when the staging register can take its data.
  assert property (@(posedge clk) disable iff (rst) cmd.issue |-> stat.issue_ok)
    else $error("read issued while staging register is blocked");

  // Only history samples can be followed by more results of the same run.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.last) |-> (out_item.result_kind == KIND_SAMPLE))
    else $error("non-sample result without last flag");

  // A sample's position lies inside its run.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.result_kind == KIND_SAMPLE)) |->
      ({1'b0, out_item.position} < out_item.returned_count))
    else $error("sample position beyond returned count");

  // The unit never takes a request while a read is being serviced.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.start_read || cmd.load_direct) |=> in_stall)
    else $error("request accepted during a read");

endmodule

>>> sim/rssi_history_ring_buffer_unit_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhrb_stream_checker
// Watches both channels of the signal strength history buffer, keeps a shadow
// of its ring and latest readings, and compares every result in order.
// ----------------------------------------------------------------------------
module rhrb_stream_checker import rhrb_pkg::*; #(
  parameter int DEPTH = HISTORY_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  rhrb_in_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  rhrb_out_t out_item,
  output int        mismatches,
  output int        outstanding
);

  logic signed [15:0] ring_shadow [DEPTH];
  int                 wr_slot;
  int                 fill_level;
  logic signed [31:0] held_wide;
  logic signed [7:0]  held_narrow;
  rhrb_out_t          expected_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Works out the results one accepted request should produce and queues them.
  task automatic predict_request(input rhrb_in_t req);
    rhrb_out_t          res;
    logic signed [15:0] chosen;
    int                 n;
    int                 first;
    res = '0;
    case (req.mode)
      MODE_TICK: begin
        if (req.wide_reading != WIDE_ABSENT) begin
          chosen = req.wide_reading[15:0];
        end else if (req.narrow_reading != NARROW_ABSENT) begin
          chosen = 16'(req.narrow_reading);
        end else begin
          chosen = SAMPLE_NONE;
        end
        ring_shadow[wr_slot] = chosen;
        wr_slot = (wr_slot + 1) % DEPTH;
        if (fill_level < DEPTH) begin
          fill_level++;
        end
        held_wide   = req.wide_reading;
        held_narrow = req.narrow_reading;
      end
      MODE_HISTORY: begin
        n = (fill_level > int'(req.capacity)) ? int'(req.capacity) : fill_level;
        if (n == 0) begin
          res.result_kind = KIND_EMPTY;
          res.last        = 1'b1;
          expected_results.push_back(res);
        end else begin
          // Once the ring has wrapped, the oldest sample sits at the write slot.
          first = ((fill_level < DEPTH) ? 0 : wr_slot) + fill_level - n;
          for (int i = 0; i < n; i++) begin
            res.result_kind    = KIND_SAMPLE;
            res.sample_value   = ring_shadow[(first + i) % DEPTH];
            res.position       = 6'(i);
            res.returned_count = 7'(n);
            res.last           = (i == n - 1);
            expected_results.push_back(res);
          end
        end
      end
      MODE_LATEST: begin
        res.result_kind   = KIND_LATEST;
        res.last          = 1'b1;
        res.latest_wide   = held_wide;
        res.latest_narrow = held_narrow;
        expected_results.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  task automatic field_check(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result(input rhrb_out_t got);
    rhrb_out_t want;
    if (expected_results.size() == 0) begin
      $error("result with no request pending: kind %0d value %0d", got.result_kind,
             got.sample_value);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      field_check("result_kind", want.result_kind, got.result_kind);
      field_check("sample_value", want.sample_value, got.sample_value);
      field_check("position", want.position, got.position);
      field_check("returned_count", want.returned_count, got.returned_count);
      field_check("last", want.last, got.last);
      field_check("latest_wide", want.latest_wide, got.latest_wide);
      field_check("latest_narrow", want.latest_narrow, got.latest_narrow);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      wr_slot     = 0;
      fill_level  = 0;
      held_wide   = WIDE_ABSENT;
      held_narrow = NARROW_ABSENT;
    end else begin
      if (out_valid && !out_stall) begin
        compare_result(out_item);
      end
      if (in_valid && !in_stall) begin
        predict_request(in_item);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

>>> sim/rssi_history_ring_buffer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_history_ring_buffer_unit_test
// Drives directed and random sample ticks, history reads and latest reads
// into the history buffer under changing idle and stall patterns; a checker
// alongside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module rssi_history_ring_buffer_unit_test;
  import rhrb_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         RANDOM_REQUESTS = 390;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  rhrb_in_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rhrb_out_t out_item;
  int        check_errors;
  int        results_pending;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  always #6 clk = ~clk;

  rssi_history_ring_buffer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  rhrb_stream_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .mismatches  (check_errors),
    .outstanding (results_pending)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic rhrb_in_t make_req(logic [1:0] mode, logic signed [31:0] wide,
                                        logic signed [7:0] narrow, logic [7:0] cap);
    rhrb_in_t req;
    req.mode           = mode;
    req.wide_reading   = wide;
    req.narrow_reading = narrow;
    req.capacity       = cap;
    return req;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input rhrb_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_item  = req;
    in_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    int                 sent;
    int                 pick;
    logic [1:0]         mode;
    logic signed [31:0] wide;
    logic signed [7:0]  narrow;
    logic [7:0]         cap;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed part: reset readings, empty reads, each branch of the sample
    // choice, capacity extremes and the unused mode.
    send_request(make_req(MODE_LATEST, 32'sd0, 8'sd0, 8'd0));
    send_request(make_req(MODE_HISTORY, 32'sd0, 8'sd0, 8'd255));
    send_request(make_req(MODE_UNUSED, 32'sd0, 8'sd0, 8'd0));
    send_request(make_req(MODE_TICK, WIDE_ABSENT, NARROW_ABSENT, 8'd0));
    send_request(make_req(MODE_TICK, WIDE_ABSENT, 8'sd127, 8'd255));
    send_request(make_req(MODE_TICK, WIDE_ABSENT, -8'sd127, 8'd0));
    send_request(make_req(MODE_TICK, 32'sh7FFF_FFFF, NARROW_ABSENT, 8'd0));
    send_request(make_req(MODE_TICK, 32'sh0001_8000, 8'sd5, 8'd0));
    send_request(make_req(MODE_TICK, -32'sd1, 8'sd0, 8'd0));
    send_request(make_req(MODE_LATEST, 32'sd0, 8'sd0, 8'd0));
    send_request(make_req(MODE_HISTORY, 32'sd0, 8'sd0, 8'd0));
    send_request(make_req(MODE_HISTORY, 32'sd0, 8'sd0, 8'd1));
    send_request(make_req(MODE_HISTORY, 32'sd0, 8'sd0, 8'd255));
    send_request(make_req(MODE_HISTORY, -32'sd1, -8'sd1, 8'd3));
    send_request(make_req(MODE_HISTORY, 32'sd0, 8'sd0, 8'd64));
    send_request(make_req(MODE_UNUSED, -32'sd1, -8'sd1, 8'd255));
    send_request(make_req(MODE_TICK, 32'sh0000_7FFF, 8'sd0, 8'd0));
    send_request(make_req(MODE_LATEST, -32'sd1, -8'sd1, 8'd255));
    send_request(make_req(MODE_HISTORY, 32'sd0, 8'sd0, 8'd2));

    // Random part in four idling phases; ignored requests do not count.
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      case (sent * 4 / RANDOM_REQUESTS)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 84;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 84;
        end
        default: begin
          send_idle_pct = 9;
          stall_pct     = 9;
        end
      endcase
      pick = $urandom_range(99);
      if (pick < 45) begin
        mode = MODE_TICK;
      end else if (pick < 80) begin
        mode = MODE_HISTORY;
      end else if (pick < 95) begin
        mode = MODE_LATEST;
      end else begin
        mode = MODE_UNUSED;
      end
      case ($urandom_range(7))
        0, 1, 2: wide = WIDE_ABSENT;
        3:       wide = 32'sh7FFF_FFFF;
        default: wide = $urandom;
      endcase
      narrow = ($urandom_range(3) == 0) ? NARROW_ABSENT : 8'($urandom);
      // Mostly short reads; full and over-full capacities now and then.
      case ($urandom_range(11))
        0:       cap = 8'd0;
        1:       cap = 8'd255;
        2:       cap = 8'd64;
        3:       cap = 8'd63;
        4:       cap = 8'($urandom);
        default: cap = 8'($urandom_range(12, 1));
      endcase
      send_request(make_req(mode, wide, narrow, cap));
      if (mode != MODE_UNUSED) begin
        sent++;
      end
    end
    in_valid = 1'b0;

    while (results_pending != 0) begin
      @(negedge clk);
    end
    repeat (10) @(negedge clk);
    if (check_errors == 0) begin
      $display("rssi_history_ring_buffer_unit regression: pass");
    end else begin
      $display("rssi_history_ring_buffer_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("rssi_history_ring_buffer_unit regression: fail");
    $finish;
  end

endmodule
